>>> hw/rtl/bai_pkg.sv
// Shared types and constants for the byte array insert/remove block.
package bai_pkg;

  // Default number of byte cells in the array.
  localparam int DEPTH_DEFAULT = 256;

  // Cells whose read bytes are merged into one registered group word.
  localparam int GROUP_SIZE = 16;

  // Request kinds, as carried in the req_type field.
  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_GET    = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_REMOVE = 3'd4
  } req_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Update applied along the whole cell row at once.
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PUSH   = 2'd1,
    CELL_INSERT = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  // Broadcast command to every cell.
  typedef struct packed {
    cell_op_t   op;
    logic [7:0] din;
  } cell_cmd_t;

  // Request beat payload.
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] position;
    logic [7:0] data_in;
  } req_t;

  // Response beat payload.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic [8:0] fill_count;
  } rsp_t;

endpackage

>>> hw/rtl/bai_if.sv
// Valid/ready channel interfaces for requests and responses.
interface bai_req_if;
  import bai_pkg::*;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bai_rsp_if;
  import bai_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/byte_array_insert_remove_core.sv
// Top level: byte array with push, pop, get, insert and remove over a row of cells.
// A request is taken whenever no earlier request is still in its read stage; the
// cell row shifts or writes at the accepting edge and the selected cell's byte is
// merged into group registers of sixteen cells each. In the read stage the groups are
// OR-merged and the result is loaded into the response register once that register is
// empty or being taken, so a new request is taken only after the previous response has
// been loaded. A stalled response holds the next request in its read stage. Array entries
// come out of reset undefined and are only read after being written.
module byte_array_insert_remove_core
  import bai_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  bai_req_if.sink   req,
  bai_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 8) ? CW : 8;
  localparam int NG = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int NPAD = NG * GROUP_SIZE;
  localparam logic [CW-1:0] CountMax = CW'(DEPTH);

  // Control and pending-request registers
  logic          pend;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  status_t       pend_status;
  logic          pend_rd;
  rsp_t          rsp_data;
  logic          rsp_valid;

  // Decode of the incoming request
  logic          accept;
  logic          load_rsp;
  status_t       status_next;
  logic          rd_next;
  cell_cmd_t     cmd;
  logic [IW-1:0] idx;
  logic [IW-1:0] rd_idx;
  logic [IW-1:0] pos_x;
  logic [IW-1:0] count_x;
  logic          full;

  // Cell row and read merge
  logic [7:0] cell_data [DEPTH];
  logic [7:0] rd_pad [NPAD];
  logic [7:0] grp [NG];
  logic [7:0] merged;
  logic [CW+8:0] count_wide;

  assign accept   = req.valid && req.ready;
  assign req.ready = !pend;
  assign load_rsp = pend && (!rsp_valid || rsp.ready);

  assign pos_x   = IW'(req.payload.position);
  assign count_x = IW'(count);
  assign full    = (count == CountMax);

  // Request decode: status, count update, cell command, read address
  always_comb begin
    status_next = ST_RANGE;
    rd_next     = 1'b0;
    count_next  = count;
    cmd.op      = CELL_HOLD;
    cmd.din     = req.payload.data_in;
    idx         = pos_x;
    rd_idx      = pos_x;
    case (req.payload.req_type)
      REQ_PUSH: begin
        idx = count_x;
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          count_next  = count + 1'b1;
          cmd.op      = CELL_PUSH;
        end
      end
      REQ_POP: begin
        rd_idx = count_x - 1'b1;
        if (count != '0) begin
          status_next = ST_DONE;
          rd_next     = 1'b1;
          count_next  = count - 1'b1;
        end
      end
      REQ_GET: begin
        if (pos_x < count_x) begin
          status_next = ST_DONE;
          rd_next     = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (pos_x > count_x) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          count_next  = count + 1'b1;
          cmd.op      = CELL_INSERT;
        end
      end
      REQ_REMOVE: begin
        if (pos_x < count_x) begin
          status_next = ST_DONE;
          rd_next     = 1'b1;
          count_next  = count - 1'b1;
          cmd.op      = CELL_REMOVE;
        end
      end
      default: status_next = ST_RANGE;
    endcase
    if (!accept) begin
      cmd.op = CELL_HOLD;
    end
  end

  // Row of byte cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] prev_byte;
    logic [7:0] next_byte;
    if (i == 0) begin : g_first
      assign prev_byte = cell_data[i];
    end else begin : g_mid_prev
      assign prev_byte = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_byte = cell_data[i];
    end else begin : g_mid_next
      assign next_byte = cell_data[i+1];
    end
    bai_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (idx),
      .rd_idx    (rd_idx),
      .prev_data (prev_byte),
      .next_data (next_byte),
      .data      (cell_data[i]),
      .rd_byte   (rd_pad[i])
    );
  end

  for (genvar i = DEPTH; i < NPAD; i++) begin : g_pad
    assign rd_pad[i] = 8'd0;
  end

  // First merge level: one register per group of cells, captured on accept
  for (genvar g = 0; g < NG; g++) begin : g_grp
    logic [7:0] acc;
    always_comb begin
      acc = 8'd0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        acc = acc | rd_pad[g*GROUP_SIZE + k];
      end
    end
    always_ff @(posedge clk) begin
      if (accept) begin
        grp[g] <= acc;
      end
    end
  end

  // Second merge level over the group registers
  always_comb begin
    merged = 8'd0;
    for (int g = 0; g < NG; g++) begin
      merged = merged | grp[g];
    end
  end

  assign count_wide = {9'd0, count};

  // Control state, pending request and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend  <= 1'b1;
        count <= count_next;
      end else if (load_rsp) begin
        pend <= 1'b0;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_rd     <= rd_next;
    end
    if (load_rsp) begin
      rsp_data.status     <= pend_status;
      rsp_data.data_out   <= pend_rd ? merged : 8'd0;
      rsp_data.fill_count <= count_wide[8:0];
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_data;

endmodule

>>> hw/rtl/bai_cell.sv
// One byte cell of the array row: holds a byte, shifts with its neighbors.
module bai_cell
  import bai_pkg::*;
#(
  parameter int IW = 9,
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] idx,
  input  logic [IW-1:0] rd_idx,
  input  logic [7:0]    prev_data,
  input  logic [7:0]    next_data,
  output logic [7:0]    data,
  output logic [7:0]    rd_byte
);

  localparam logic [IW-1:0] MyIdx = IW'(INDEX);

  logic [7:0] data_next;

  // Per-cell update chosen by comparing own index with the broadcast index
  always_comb begin
    data_next = data;
    case (cmd.op)
      CELL_PUSH: begin
        if (MyIdx == idx) data_next = cmd.din;
      end
      CELL_INSERT: begin
        if (MyIdx == idx) data_next = cmd.din;
        else if (MyIdx > idx) data_next = prev_data;
      end
      CELL_REMOVE: begin
        if (MyIdx >= idx) data_next = next_data;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Read select: only the addressed cell drives a nonzero byte
  assign rd_byte = (MyIdx == rd_idx) ? data : 8'd0;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the byte array core: edge requests, fill to full, then random traffic.
module testbench;
  import bai_pkg::*;

  localparam int ARRAY_DEPTH = DEPTH_DEFAULT;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;

  // Request kinds the block does not define
  localparam logic [2:0] REQ_UNUSED_A = 3'd5;
  localparam logic [2:0] REQ_UNUSED_B = 3'd6;
  localparam logic [2:0] REQ_UNUSED_C = 3'd7;

  logic clk;
  logic rst;

  bai_req_if req ();
  bai_rsp_if rsp ();

  byte_array_insert_remove_core #(.DEPTH(ARRAY_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow copy of the array contents and fill count
  logic [7:0] held_bytes [ARRAY_DEPTH];
  int held_count;

  rsp_t pending_rsp [$];
  rsp_t want_rsp;
  int error_count;
  int send_idle_pct;
  int stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow array and return the response it must give
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int k;
    res.status = ST_RANGE;
    res.data_out = 8'h00;
    case (r.req_type)
      REQ_PUSH: begin
        if (held_count >= ARRAY_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          held_bytes[held_count] = r.data_in;
          held_count++;
          res.status = ST_DONE;
        end
      end
      REQ_POP: begin
        if (held_count > 0) begin
          held_count--;
          res.data_out = held_bytes[held_count];
          res.status = ST_DONE;
        end
      end
      REQ_GET: begin
        if (int'(r.position) < held_count) begin
          res.data_out = held_bytes[r.position];
          res.status = ST_DONE;
        end
      end
      REQ_INSERT: begin
        // range check wins over the full check
        if (int'(r.position) > held_count) begin
          res.status = ST_RANGE;
        end else if (held_count >= ARRAY_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (k = held_count; k > int'(r.position); k--) held_bytes[k] = held_bytes[k - 1];
          held_bytes[r.position] = r.data_in;
          held_count++;
          res.status = ST_DONE;
        end
      end
      REQ_REMOVE: begin
        if (int'(r.position) < held_count) begin
          res.data_out = held_bytes[r.position];
          for (k = int'(r.position); k + 1 < held_count; k++) held_bytes[k] = held_bytes[k + 1];
          held_count--;
          res.status = ST_DONE;
        end
      end
      default: begin
        res.status = ST_RANGE;
      end
    endcase
    res.fill_count = 9'(held_count);
    return res;
  endfunction

  // Highest index an insert at the end may use, limited by the position width
  function automatic logic [7:0] end_position();
    return (held_count > 255) ? 8'd255 : 8'(held_count);
  endfunction

  // Drive one request beat, wait for it to be taken, then queue the response it must give
  task automatic send_req(logic [2:0] kind, logic [7:0] pos, logic [7:0] din);
    req_t r;
    r.req_type = kind;
    r.position = pos;
    r.data_in = din;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      req.payload <= req_t'($urandom);
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_rsp.push_back(apply_request(r));
  endtask

  task automatic set_idling(int src_pct, int sink_pct);
    send_idle_pct = src_pct;
    stall_pct = sink_pct;
  endtask

  // Empty array cases, field extremes, every kind, shifts at both ends
  task automatic test_empty_and_edges();
    send_req(REQ_POP, 8'd0, 8'd0);
    send_req(REQ_GET, 8'd0, 8'd0);
    send_req(REQ_REMOVE, 8'd0, 8'd0);
    send_req(REQ_INSERT, 8'd1, 8'h11);
    send_req(REQ_INSERT, 8'd0, 8'h00);
    send_req(REQ_PUSH, 8'd255, 8'hFF);
    send_req(REQ_INSERT, 8'd1, 8'h5A);
    send_req(REQ_INSERT, 8'd3, 8'hA5);
    send_req(REQ_INSERT, 8'd0, 8'h3C);
    send_req(REQ_GET, 8'd0, 8'hFF);
    send_req(REQ_GET, 8'd4, 8'd0);
    send_req(REQ_GET, 8'd5, 8'd0);
    send_req(REQ_GET, 8'd255, 8'd0);
    send_req(REQ_INSERT, 8'd255, 8'h77);
    send_req(REQ_REMOVE, 8'd2, 8'd0);
    send_req(REQ_REMOVE, 8'd3, 8'd0);
    send_req(REQ_REMOVE, 8'd3, 8'd0);
    send_req(REQ_REMOVE, 8'd0, 8'd0);
    send_req(REQ_UNUSED_A, 8'd255, 8'hFF);
    send_req(REQ_UNUSED_B, 8'd0, 8'hFF);
    send_req(REQ_UNUSED_C, 8'd1, 8'h00);
    send_req(REQ_POP, 8'd0, 8'd0);
    send_req(REQ_POP, 8'd0, 8'd0);
    send_req(REQ_POP, 8'd0, 8'd0);
  endtask

  // Fill the whole array, hit the full cases, then drain to empty
  task automatic test_fill_to_full();
    while (held_count < ARRAY_DEPTH) begin
      if ($urandom_range(0, 2) == 0)
        send_req(REQ_INSERT, 8'($urandom_range(0, end_position())), 8'($urandom));
      else
        send_req(REQ_PUSH, 8'($urandom), 8'($urandom));
    end
    send_req(REQ_PUSH, 8'd0, 8'h42);
    send_req(REQ_INSERT, 8'd0, 8'h42);
    send_req(REQ_INSERT, 8'd255, 8'h42);
    send_req(REQ_GET, 8'd255, 8'd0);
    send_req(REQ_REMOVE, 8'd255, 8'd0);
    send_req(REQ_INSERT, 8'd255, 8'hC3);
    send_req(REQ_GET, 8'd0, 8'd0);
    send_req(REQ_REMOVE, 8'd0, 8'd0);
    send_req(REQ_INSERT, 8'd0, 8'h81);
    send_req(REQ_POP, 8'd0, 8'd0);
    send_req(REQ_PUSH, 8'd0, 8'h18);
    while (held_count > 0) begin
      if ($urandom_range(0, 1) == 0)
        send_req(REQ_REMOVE, 8'($urandom_range(0, held_count - 1)), 8'($urandom));
      else
        send_req(REQ_POP, 8'($urandom), 8'($urandom));
    end
    send_req(REQ_POP, 8'd0, 8'd0);
  endtask

  // Random traffic in bursts that either grow or shrink the array
  task automatic test_random_mix(int n_items);
    logic [2:0] kind;
    logic [7:0] pos;
    bit grow;
    int roll;
    int pick;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0) grow = ($urandom_range(0, 2) != 0) || (held_count < 4);
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        kind = 3'($urandom_range(REQ_UNUSED_A, REQ_UNUSED_C));
      end else if (grow) begin
        kind = (roll < 38) ? REQ_PUSH : (roll < 72) ? REQ_INSERT :
               (roll < 86) ? REQ_GET : (roll < 94) ? REQ_REMOVE : REQ_POP;
      end else begin
        kind = (roll < 13) ? REQ_PUSH : (roll < 24) ? REQ_INSERT :
               (roll < 44) ? REQ_GET : (roll < 72) ? REQ_REMOVE : REQ_POP;
      end
      // mostly legal indexes, some at the end, some anywhere
      pick = $urandom_range(0, 9);
      if (pick == 0)
        pos = 8'($urandom);
      else if (pick == 1)
        pos = end_position();
      else if (kind == REQ_INSERT)
        pos = 8'($urandom_range(0, end_position()));
      else if (held_count > 0)
        pos = 8'($urandom_range(0, held_count - 1));
      else
        pos = 8'($urandom);
      send_req(kind, pos, 8'($urandom));
    end
  endtask

  // Response sink with random back pressure
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each response beat with the oldest outstanding prediction
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response beat with nothing outstanding: status %0d data_out %0d fill_count %0d",
               rsp.payload.status, rsp.payload.data_out, rsp.payload.fill_count);
        error_count++;
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (rsp.payload.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, rsp.payload.status);
          error_count++;
        end
        if (rsp.payload.data_out !== want_rsp.data_out) begin
          $error("data_out: expected %0d, got %0d", want_rsp.data_out, rsp.payload.data_out);
          error_count++;
        end
        if (rsp.payload.fill_count !== want_rsp.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want_rsp.fill_count,
                 rsp.payload.fill_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no beat on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL byte_array_insert_remove_core");
    $finish;
  end

  // Test sequence
  initial begin
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.payload <= '0;
    error_count = 0;
    held_count = 0;
    set_idling(0, 0);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    set_idling(32, 32);
    test_empty_and_edges();
    set_idling(0, 0);
    test_fill_to_full();

    set_idling(0, 0);
    test_random_mix(20);
    set_idling(76, 0);
    test_random_mix(20);
    set_idling(0, 76);
    test_random_mix(20);
    set_idling(32, 32);
    test_random_mix(20);

    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("PASS byte_array_insert_remove_core");
    end else begin
      $display("FAIL byte_array_insert_remove_core");
    end
    $finish;
  end

endmodule
